// File: design/bcgd_pkg.sv
// Shared types and constants for the button click gesture detector.
// No dependencies; every other design file except bcgd_out_if refers to it by scoped names.
package bcgd_pkg;

  // field widths
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // result queue geometry: each entry holds all results of one input word
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // input opcodes
  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd800;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST = 16'd300;

  typedef enum logic [1:0] {
    GEST_CLICK  = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LONG   = 2'd2
  } gesture_t;

  // results caused by one input word: one or two gestures
  typedef struct packed {
    logic     two;
    gesture_t g0;
    gesture_t g1;
  } result_word_t;

endpackage

// File: design/bcgd_in_if.sv
// Input channel of the gesture detector: level change or poll word.
// Depends on bcgd_pkg for the time stamp width.
interface bcgd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic                        level_pressed;
  logic [bcgd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output opcode, output level_pressed, output now_ms,
                  input ready);
  modport sink   (input valid, input opcode, input level_pressed, input now_ms,
                  output ready);
endinterface

// File: design/bcgd_out_if.sv
// Result channel of the gesture detector: one gesture per word.
// Depends on nothing outside this file.
interface bcgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;
  logic       last_of_run;

  modport source (output valid, output gesture, output last_of_run, input ready);
  modport sink   (input valid, input gesture, input last_of_run, output ready);
endinterface

// File: design/bcgd_cfg_if.sv
// Configuration write channel of the gesture detector.
// Depends on bcgd_pkg for index and data widths.
interface bcgd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bcgd_pkg::CFG_IDX_W-1:0]  index;
  logic [bcgd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/button_click_gesture_detector.sv
// An input word is registered in the input stage, evaluated in the next cycle
// and its results are written into the result queue that feeds the output.
// Throughput: one input word per cycle while the queue has room; the output
// gives one gesture per cycle while the sink is ready, so a word with two
// results is offered as two output words.
// Reset: synchronous, active low; clears the gesture state, the queue and
// restores the configuration defaults (20, 800, 300 ms).
module button_click_gesture_detector (
  input  logic       clk,
  input  logic       rst_n,
  bcgd_in_if.sink    in_ch,
  bcgd_out_if.source out_ch,
  bcgd_cfg_if.sink   cfg_ch
);

  localparam int TW = bcgd_pkg::TIME_W;
  localparam int DW = bcgd_pkg::CFG_DATA_W;

  // configuration
  logic [DW-1:0] debounce_r, long_press_r, double_click_r;

  // input stage
  logic          stg_v_r;
  logic          stg_op_r;
  logic          stg_lvl_r;
  logic [TW-1:0] stg_now_r;

  // gesture state
  logic          edge_seen_r, edge_seen_nxt;
  logic [TW-1:0] last_edge_r, last_edge_nxt;
  logic          stable_r, stable_nxt;
  logic [TW-1:0] press_time_r, press_time_nxt;
  logic          long_done_r, long_done_nxt;
  logic          click_wait_r, click_wait_nxt;
  logic [TW-1:0] first_rel_r, first_rel_nxt;

  // result queue
  bcgd_pkg::result_word_t             queue_r [bcgd_pkg::QUEUE_DEPTH];
  logic [bcgd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [bcgd_pkg::QUEUE_CNT_W-1:0]   cnt_r;
  logic                               sub_r;

  logic [1:0]                         res_n;
  bcgd_pkg::gesture_t                 res_g0, res_g1;
  bcgd_pkg::result_word_t             head;
  logic                               push, pop_word, pop_entry, head_last;

  logic [TW-1:0] edge_gap, held, rel_gap;
  logic          in_take;

  // accept a word only if the queue can take both pending words
  assign in_ch.ready = (cnt_r + bcgd_pkg::QUEUE_CNT_W'(stg_v_r))
                       < bcgd_pkg::QUEUE_CNT_W'(bcgd_pkg::QUEUE_DEPTH);
  assign in_take     = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // wrapped time differences
  assign edge_gap = stg_now_r - last_edge_r;
  assign held     = stg_now_r - press_time_r;
  assign rel_gap  = stg_now_r - first_rel_r;

  // evaluate the staged word against the gesture state
  always_comb begin
    edge_seen_nxt  = edge_seen_r;
    last_edge_nxt  = last_edge_r;
    stable_nxt     = stable_r;
    press_time_nxt = press_time_r;
    long_done_nxt  = long_done_r;
    click_wait_nxt = click_wait_r;
    first_rel_nxt  = first_rel_r;
    res_n  = 2'd0;
    res_g0 = bcgd_pkg::GEST_CLICK;
    res_g1 = bcgd_pkg::GEST_CLICK;
    if (stg_v_r) begin
      if (stg_op_r == bcgd_pkg::OP_POLL) begin
        // confirm a waiting click once the window has passed
        if (click_wait_r && (rel_gap > TW'(double_click_r))) begin
          click_wait_nxt = 1'b0;
          res_g0 = bcgd_pkg::GEST_CLICK;
          res_n  = 2'd1;
        end
        // fire a long press while still held
        if (stable_r && !long_done_r && (held >= TW'(long_press_r))) begin
          long_done_nxt  = 1'b1;
          click_wait_nxt = 1'b0;
          if (res_n == 2'd0) begin
            res_g0 = bcgd_pkg::GEST_LONG;
          end else begin
            res_g1 = bcgd_pkg::GEST_LONG;
          end
          res_n = res_n + 2'd1;
        end
      end else if (!(edge_seen_r && (edge_gap < TW'(debounce_r)))) begin
        edge_seen_nxt = 1'b1;
        last_edge_nxt = stg_now_r;
        if (stg_lvl_r != stable_r) begin
          stable_nxt = stg_lvl_r;
          if (stg_lvl_r) begin
            press_time_nxt = stg_now_r;
            long_done_nxt  = 1'b0;
          end else if (!long_done_r) begin
            // release: long press, first click, double click or late click
            if (held >= TW'(long_press_r)) begin
              click_wait_nxt = 1'b0;
              res_g0 = bcgd_pkg::GEST_LONG;
              res_n  = 2'd1;
            end else if (!click_wait_r) begin
              click_wait_nxt = 1'b1;
              first_rel_nxt  = stg_now_r;
            end else if (rel_gap <= TW'(double_click_r)) begin
              click_wait_nxt = 1'b0;
              res_g0 = bcgd_pkg::GEST_DOUBLE;
              res_n  = 2'd1;
            end else begin
              first_rel_nxt = stg_now_r;
              res_g0 = bcgd_pkg::GEST_CLICK;
              res_n  = 2'd1;
            end
          end
        end
      end
    end
  end

  // queue head and output word
  assign push      = (res_n != 2'd0);
  assign head      = queue_r[rd_ptr_r];
  assign head_last = sub_r | ~head.two;
  assign pop_word  = out_ch.valid & out_ch.ready;
  assign pop_entry = pop_word & head_last;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.gesture     = sub_r ? head.g1 : head.g0;
  assign out_ch.last_of_run = head_last;

  // hold configuration, stage, state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= bcgd_pkg::DEBOUNCE_RST;
      long_press_r   <= bcgd_pkg::LONG_PRESS_RST;
      double_click_r <= bcgd_pkg::DOUBLE_CLICK_RST;
      stg_v_r        <= 1'b0;
      edge_seen_r    <= 1'b0;
      last_edge_r    <= '0;
      stable_r       <= 1'b0;
      press_time_r   <= '0;
      long_done_r    <= 1'b0;
      click_wait_r   <= 1'b0;
      first_rel_r    <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      cnt_r          <= '0;
      sub_r          <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          bcgd_pkg::CFG_DEBOUNCE:     debounce_r     <= cfg_ch.data;
          bcgd_pkg::CFG_LONG_PRESS:   long_press_r   <= cfg_ch.data;
          bcgd_pkg::CFG_DOUBLE_CLICK: double_click_r <= cfg_ch.data;
          default: ;
        endcase
      end
      stg_v_r      <= in_take;
      edge_seen_r  <= edge_seen_nxt;
      last_edge_r  <= last_edge_nxt;
      stable_r     <= stable_nxt;
      press_time_r <= press_time_nxt;
      long_done_r  <= long_done_nxt;
      click_wait_r <= click_wait_nxt;
      first_rel_r  <= first_rel_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        sub_r    <= 1'b0;
      end else if (pop_word) begin
        sub_r <= 1'b1;
      end
      cnt_r <= cnt_r + bcgd_pkg::QUEUE_CNT_W'(push)
                     - bcgd_pkg::QUEUE_CNT_W'(pop_entry);
    end
  end

  // payload: staged word and queue entries
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_op_r  <= in_ch.opcode;
      stg_lvl_r <= in_ch.level_pressed;
      stg_now_r <= in_ch.now_ms;
    end
    if (push) begin
      queue_r[wr_ptr_r] <= '{two: (res_n == 2'd2), g0: res_g0, g1: res_g1};
    end
  end

endmodule
